### rtl/hpq_pkg.sv
`default_nettype none

package hpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 16;
    localparam int FILL_W     = 7;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = CNT_W + 1;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int IN_DATA_W  = ((KEY_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_W + TAG_W + FILL_W + 7) / 8) * 8;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_STEP,
        ST_DN_CMP_L,
        ST_DN_CMP_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        status_t                 status;
        fill_t                   fill;
    } result_t;

    function automatic fill_t to_fill(cnt_t c);
        return FILL_W'(c);
    endfunction

endpackage

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of CAPACITY entries, each a signed 32-bit
// key with a 16-bit tag.
// Input channel s_axis: one transaction is one request. tuser selects push
// (0) or pop (1); tdata carries the key and tag used by a push.
// Output channel m_axis: exactly one transaction per request, in order. It
// gives the popped key and tag (zero for a push or a failed pop), the status
// in tuser (ok, pop on empty, push refused when full) and the fill count.
// A push places the new entry at the end and lets it rise one level at a
// time; a pop returns the root and lets the last entry sink from there one
// level at a time. A new request is taken only once the result of the last
// one has moved to the output register, so requests never overlap. The pace
// is set by the one two-read, one-write heap memory and the single key
// comparator, both shared by every step of the sift.
// s_axis_tready is low until the result has moved to the output register.
// If the receiver stalls, the result is held; a finished second result waits
// inside until the register frees up.
// Reset empties the queue at once; the memory needs no clearing pass.

`default_nettype none

module binary_min_heap_queue
    import hpq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[31:0], tag[47:32]
    input  wire logic [0:0]            s_axis_tuser,  // req_type[0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // out_key[31:0], out_tag[47:32],
                                                      // fill_count[54:48], zero[55]
    output logic [1:0]                 m_axis_tuser   // status[1:0]
);

    logic    res_valid, res_ready;
    result_t res;
    entry_t  in_entry;
    req_t    in_req;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    assign in_entry.key = s_axis_tdata[KEY_W-1:0];
    assign in_entry.tag = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];
    assign in_req       = req_t'(s_axis_tuser[0]);

    hpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .in_entry  (in_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - KEY_W - TAG_W - FILL_W){1'b0}},
                            out_reg.fill, out_reg.tag, out_reg.key};
    assign m_axis_tuser  = out_reg.status;

endmodule

`default_nettype wire

### rtl/hpq_ram.sv
`default_nettype none

module hpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so the sequencer may keep using it
    // in later states.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

### rtl/hpq_ctrl.sv
`default_nettype none

module hpq_ctrl
    import hpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire req_t    in_req,
    input  wire entry_t  in_entry,
    output logic         res_valid,
    input  wire logic    res_ready,
    output result_t      res
);

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    idx_reg, idx_next;
    entry_t  item_reg, item_next;
    result_t res_reg, res_next;
    logic    left_win_reg, left_win_next;

    logic    wr_en, rd_en;
    addr_t   wr_addr, rd_addr_a, rd_addr_b;
    entry_t  wr_data, rd_data_a, rd_data_b;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic    key_lt;
    idx_t    child;
    idx_t    child_r;

    hpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // The one key comparator shared by every step of both sift directions.
    assign key_lt = cmp_a < cmp_b;

    assign child   = {idx_reg, 1'b0};
    assign child_r = child + idx_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        left_win_reg <= left_win_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        left_win_next = left_win_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_t'(idx_reg - cnt_t'(1));
        wr_data       = item_reg;
        rd_en         = 1'b0;
        rd_addr_a     = '0;
        rd_addr_b     = '0;
        cmp_a         = item_reg.key;
        cmp_b         = rd_data_a.key;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next.key = '0;
                    res_next.tag = '0;
                    if (in_req == REQ_PUSH)
                    begin
                        if (count_reg == cnt_t'(CAPACITY))
                        begin
                            res_next.status = STAT_FULL;
                            res_next.fill   = to_fill(count_reg);
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            item_next       = in_entry;
                            idx_next        = count_reg + cnt_t'(1);
                            count_next      = count_reg + cnt_t'(1);
                            res_next.status = STAT_OK;
                            res_next.fill   = to_fill(count_reg + cnt_t'(1));
                            state_next      = ST_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = STAT_EMPTY;
                            res_next.fill   = to_fill(count_reg);
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            rd_en           = 1'b1;
                            rd_addr_a       = '0;
                            rd_addr_b       = addr_t'(count_reg - cnt_t'(1));
                            count_next      = count_reg - cnt_t'(1);
                            idx_next        = cnt_t'(1);
                            res_next.status = STAT_OK;
                            res_next.fill   = to_fill(count_reg - cnt_t'(1));
                            state_next      = ST_DN_LOAD;
                        end
                    end
                end
            end

            ST_UP:
            begin
                if (idx_reg == cnt_t'(1))
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr_a  = addr_t'((idx_reg >> 1) - cnt_t'(1));
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                cmp_a = item_reg.key;
                cmp_b = rd_data_a.key;
                wr_en = 1'b1;
                if (key_lt)
                begin
                    // The parent moves down into the hole; the new entry keeps rising.
                    wr_data    = rd_data_a;
                    idx_next   = idx_reg >> 1;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DN_LOAD:
            begin
                res_next.key = rd_data_a.key;
                res_next.tag = rd_data_a.tag;
                item_next    = rd_data_b;
                state_next   = ST_DN_STEP;
            end

            ST_DN_STEP:
            begin
                if (child > idx_t'(count_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr_a  = addr_t'(child - idx_t'(1));
                    rd_addr_b  = addr_t'(child);
                    state_next = ST_DN_CMP_L;
                end
            end

            ST_DN_CMP_L:
            begin
                cmp_a         = rd_data_a.key;
                cmp_b         = item_reg.key;
                left_win_next = key_lt;
                state_next    = ST_DN_CMP_R;
            end

            ST_DN_CMP_R:
            begin
                cmp_a = rd_data_b.key;
                cmp_b = left_win_reg ? rd_data_a.key : item_reg.key;
                wr_en = 1'b1;
                if ((child_r <= idx_t'(count_reg)) && key_lt)
                begin
                    wr_data    = rd_data_b;
                    idx_next   = cnt_t'(child_r);
                    state_next = ST_DN_STEP;
                end
                else if (left_win_reg)
                begin
                    wr_data    = rd_data_a;
                    idx_next   = cnt_t'(child);
                    state_next = ST_DN_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### verif/heap_queue_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the heap queue and keeps its own copy of
// the heap. Every accepted request is applied to that copy and yields the
// result the block should return. Every returned result is compared, field
// by field, with the oldest result still outstanding.
module heap_queue_checker
    import hpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [1:0]            m_axis_tuser,
    output int                    error_count,
    output int                    pending_count,
    output int                    push_count,
    output int                    refused_count,
    output int                    pop_count,
    output int                    empty_count,
    output int                    peak_fill
);

    localparam int FILL_LO = KEY_W + TAG_W;
    localparam int PAD_LO  = KEY_W + TAG_W + FILL_W;

    entry_t      heap_mem [1:CAPACITY];
    int unsigned heap_size;
    result_t     expected_results [$];

    result_t                 want;
    entry_t                  in_item;
    logic signed [KEY_W-1:0] got_key;
    logic [TAG_W-1:0]        got_tag;
    logic [FILL_W-1:0]       got_fill;
    logic [1:0]              got_status;
    logic [OUT_DATA_W-PAD_LO-1:0] got_pad;

    function automatic logic key_below(int unsigned a, int unsigned b);
        return $signed(heap_mem[a].key) < $signed(heap_mem[b].key);
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        entry_t held;
        held        = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = held;
    endfunction

    // Applies one request to the local heap and returns the result it gives.
    function automatic result_t apply_request(req_t req, entry_t item);
        result_t     res;
        int unsigned pos;
        int unsigned child;
        int unsigned best;
        res        = '0;
        res.status = STAT_OK;
        if (req == REQ_PUSH)
        begin
            if (heap_size >= CAPACITY)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                heap_size++;
                pos = heap_size;
                heap_mem[pos] = item;
                while (pos > 1 && key_below(pos, pos / 2))
                begin
                    swap_entries(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end
        else if (heap_size == 0)
        begin
            res.status = STAT_EMPTY;
        end
        else
        begin
            res.key     = heap_mem[1].key;
            res.tag     = heap_mem[1].tag;
            heap_mem[1] = heap_mem[heap_size];
            heap_size--;
            pos = 1;
            // The left child wins a tie; a move needs a strictly smaller key.
            while (2 * pos <= heap_size)
            begin
                child = 2 * pos;
                best  = pos;
                if (key_below(child, best))
                    best = child;
                if (child + 1 <= heap_size && key_below(child + 1, best))
                    best = child + 1;
                if (best == pos)
                    break;
                swap_entries(pos, best);
                pos = best;
            end
        end
        res.fill = FILL_W'(heap_size);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size = 0;
            expected_results.delete();
            error_count   = 0;
            pending_count = 0;
            push_count    = 0;
            refused_count = 0;
            pop_count     = 0;
            empty_count   = 0;
            peak_fill     = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_item.key = s_axis_tdata[KEY_W-1:0];
                in_item.tag = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];
                want = apply_request(req_t'(s_axis_tuser[0]), in_item);
                expected_results.insert(expected_results.size(), want);
                case (want.status)
                    STAT_FULL:  refused_count++;
                    STAT_EMPTY: empty_count++;
                    default:
                    begin
                        if (req_t'(s_axis_tuser[0]) == REQ_PUSH)
                            push_count++;
                        else
                            pop_count++;
                    end
                endcase
                if (int'(heap_size) > peak_fill)
                    peak_fill = int'(heap_size);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_key    = m_axis_tdata[KEY_W-1:0];
                got_tag    = m_axis_tdata[FILL_LO-1:KEY_W];
                got_fill   = m_axis_tdata[PAD_LO-1:FILL_LO];
                got_pad    = m_axis_tdata[OUT_DATA_W-1:PAD_LO];
                got_status = m_axis_tuser;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no request outstanding: tdata %h tuser %0d",
                           m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got_key !== want.key)
                    begin
                        $error("out_key: expected %0d, actual %0d", want.key, got_key);
                        error_count++;
                    end
                    if (got_tag !== want.tag)
                    begin
                        $error("out_tag: expected %0d, actual %0d", want.tag, got_tag);
                        error_count++;
                    end
                    if (got_status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        error_count++;
                    end
                    if (got_fill !== want.fill)
                    begin
                        $error("fill_count: expected %0d, actual %0d", want.fill, got_fill);
                        error_count++;
                    end
                    if (got_pad !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %0d", got_pad);
                        error_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### verif/binary_min_heap_queue_test.sv
`timescale 1ns / 100ps

module binary_min_heap_queue_test
    import hpq_pkg::*;
();

    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int error_count;
    int pending_count;
    int push_count;
    int refused_count;
    int pop_count;
    int empty_count;
    int peak_fill;

    int items_sent = 0;
    int queue_fill = 0;
    int cycle_count = 0;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    always #5 clk = ~clk;

    binary_min_heap_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    heap_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending_count (pending_count),
        .push_count    (push_count),
        .refused_count (refused_count),
        .pop_count     (pop_count),
        .empty_count   (empty_count),
        .peak_fill     (peak_fill)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 4))
            0, 1: k = $urandom;
            // A narrow range around zero gives many equal keys.
            2: k = KEY_W'($urandom_range(0, 12)) - KEY_W'(6);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: k = 32'h8000_0000;
                    1: k = 32'h7FFF_FFFF;
                    2: k = '0;
                    default: k = '1;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    k = 32'h8000_0000 + KEY_W'($urandom_range(0, 3));
                else
                    k = 32'h7FFF_FFFF - KEY_W'($urandom_range(0, 3));
            end
        endcase
        return k;
    endfunction

    // Offers one request and returns once the transaction has taken place.
    task automatic send_req(req_t req, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
            s_axis_tuser  <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, k};
        s_axis_tuser  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (req == REQ_PUSH && queue_fill < CAPACITY)
            queue_fill++;
        else if (req == REQ_POP && queue_fill > 0)
            queue_fill--;
    endtask

    initial
    begin
        int episode;
        int kind;
        int len;
        int push_pct;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PUSH;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pop on an empty queue, key extremes, equal keys, then
        // drain down to one more pop on an empty queue.
        send_req(REQ_POP, $urandom, TAG_W'($urandom));
        send_req(REQ_PUSH, 32'h7FFF_FFFF, 16'hFFFF);
        send_req(REQ_PUSH, 32'h8000_0000, 16'h0000);
        send_req(REQ_PUSH, 32'h0000_0000, 16'h1234);
        send_req(REQ_PUSH, 32'hFFFF_FFFF, 16'h00FF);
        send_req(REQ_PUSH, 32'h0000_0001, 16'h8000);
        send_req(REQ_PUSH, 32'h0000_0005, 16'hAAAA);
        send_req(REQ_PUSH, 32'h0000_0005, 16'h5555);
        send_req(REQ_PUSH, 32'h0000_0005, 16'h0001);
        send_req(REQ_PUSH, 32'h8000_0001, 16'h7FFF);
        repeat (10) send_req(REQ_POP, $urandom, TAG_W'($urandom));

        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            episode++;
            if (items_sent > ITEM_TARGET - 150)
            begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            if (episode == 3)
                long_hold_req = 1'b1;
            kind = (episode == 1) ? 0 : $urandom_range(0, 4);
            case (kind)
                0:
                begin
                    // Fill up completely, then a few pushes that are refused.
                    while (queue_fill < CAPACITY)
                        send_req(REQ_PUSH, pick_key(), TAG_W'($urandom));
                    repeat ($urandom_range(1, 3))
                        send_req(REQ_PUSH, pick_key(), TAG_W'($urandom));
                end
                1:
                begin
                    while (queue_fill > 0)
                        send_req(REQ_POP, $urandom, TAG_W'($urandom));
                    repeat ($urandom_range(1, 2))
                        send_req(REQ_POP, $urandom, TAG_W'($urandom));
                end
                default:
                begin
                    len      = $urandom_range(20, 60);
                    push_pct = (kind == 2) ? 70 : (kind == 3) ? 50 : 30;
                    repeat (len)
                    begin
                        if ($urandom_range(0, 99) < push_pct)
                            send_req(REQ_PUSH, pick_key(), TAG_W'($urandom));
                        else
                            send_req(REQ_POP, $urandom, TAG_W'($urandom));
                    end
                end
            endcase
            if (episode % 6 == 0 && tx_gaps)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                wait (pending_count == 0);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests: %0d pushes stored, %0d refused when full,",
                 items_sent, push_count, refused_count);
        $display("%0d pops served, %0d pops on an empty queue, peak fill %0d of %0d.",
                 pop_count, empty_count, peak_fill, CAPACITY);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
